FILE: sv/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg: shared types and constants of the grid ray caster
// Holds fixed field widths, map geometry and the sequencer-to-divider struct.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DirW   = 16;
  localparam int unsigned DistW  = 16;
  localparam int unsigned TileW  = 6;
  localparam int unsigned DirFracBits = 14;

  // Map side in tiles (power of two, at most 2^TileW) and fraction bits of Q6.10
  localparam int unsigned MapSide  = 64;
  localparam int unsigned FracBits = 10;

  // Action codes
  localparam logic ActWrite = 1'b0;
  localparam logic ActCast  = 1'b1;

  // Divider request from the sequencer
  typedef struct packed {
    logic        start;
    logic [14:0] divisor;
  } div_req_t;

endpackage

FILE: sv/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div: shared restoring divider
// Computes floor(2^NUM_EXP / divisor), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdr_div #(
  parameter int unsigned NUM_EXP = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdr_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [NUM_EXP:0]  quot_o
);

  localparam int unsigned CntW = $clog2(NUM_EXP + 2);

  logic [NUM_EXP:0] quot_q, quot_d;
  logic [16:0]      rem_q, rem_d;
  logic [14:0]      dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [16:0]      trial;

  // Shift in one dividend bit: only the top bit of 2^NUM_EXP is set
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], (cnt_q == CntW'(NUM_EXP))};
    if (req_i.start) begin
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CntW'(NUM_EXP);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {2'b00, dvs_q}) begin
        rem_d  = trial - {2'b00, dvs_q};
        quot_d = {quot_q[NUM_EXP-1:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NUM_EXP-1:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: sv/grid_dda_ray_distance.sv
// Cast (busy_o high throughout): read the origin tile (S_RD0), test it (S_CHK0),
// take two reciprocals on the shared divider (S_DIVX, S_DIVY), multiply
// (S_MULX, S_MULY), then S_STEP, S_LOOK and S_CHK1 per tile boundary crossed.
// A solid origin tile ends the cast at S_CHK0; a tile write busies only S_WR.
// One item in flight; done_o strobes in the first idle cycle after a cast, no stall.
// Reset clears control state only; the tile map is undefined until written.
module grid_dda_ray_distance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [5:0]  tile_x_i,
  input  logic [5:0]  tile_y_i,
  input  logic        tile_solid_i,
  input  logic [15:0] origin_x_i,
  input  logic [15:0] origin_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic [15:0] max_dist_i,
  output logic        done_o,
  output logic [15:0] hit_dist_o
);

  localparam int unsigned MapSide  = gdr_pkg::MapSide;
  localparam int unsigned FracBits = gdr_pkg::FracBits;
  localparam int unsigned NumExp = gdr_pkg::DirFracBits + FracBits;
  localparam int unsigned MW     = $clog2(MapSide);
  localparam int unsigned TW     = 16 - FracBits + 2;    // signed tile coord
  localparam int unsigned DW     = 42;                   // distance accumulator
  localparam int unsigned PW     = NumExp + FracBits + 2; // fraction times finite step
  localparam logic [DW-1:0] InfStep = DW'(64'd1 << 40);

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_RD0, S_CHK0, S_DIVX, S_DIVY, S_MULX, S_MULY, S_STEP, S_LOOK,
    S_CHK1, S_OUT
  } state_e;

  state_e state_q;
  logic [DW-1:0] invx_q, invy_q, nx_q, ny_q, dist_q;
  logic signed [TW-1:0] mx_q, my_q;
  logic sx_q, sy_q;
  logic [15:0] ox_q, oy_q, maxd_q, res_q;
  logic [14:0] magx_q, magy_q;
  logic done_q, dstart_q;
  logic [14:0] ddiv_q;

  // Tile map
  logic mem [MapSide*MapSide];
  logic rd_q;
  logic [2*MW-1:0] rd_addr;
  logic wr_en;
  logic in_map;

  gdr_pkg::div_req_t dreq;
  logic             ddone;
  logic [NumExp:0]  dquot;

  assign dreq.start   = dstart_q;
  assign dreq.divisor = ddiv_q;

  gdr_div #(.NUM_EXP(NumExp)) u_div (
    .clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot)
  );

  // Magnitude of a direction; -32768 clips into 15 bits as 2^15 is handled apart
  function automatic logic [15:0] mag16(logic signed [15:0] d);
    mag16 = d[15] ? 16'(-d) : 16'(d);
  endfunction

  logic [15:0] magx_in, magy_in;
  assign magx_in = mag16(dir_x_i);
  assign magy_in = mag16(dir_y_i);

  // Tile in range test on the signed walk position
  assign in_map = (mx_q >= 0) && (my_q >= 0) &&
                  (mx_q < $signed(TW'(MapSide))) && (my_q < $signed(TW'(MapSide)));
  assign rd_addr = {my_q[MW-1:0], mx_q[MW-1:0]};
  assign wr_en   = start_i && !busy_o && (action_i == gdr_pkg::ActWrite) &&
                   (32'(tile_x_i) < MapSide) && (32'(tile_y_i) < MapSide);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[{tile_y_i[MW-1:0], tile_x_i[MW-1:0]}] <= tile_solid_i;
    rd_q <= mem[rd_addr];
  end

  // Reciprocal of one magnitude, with zero and 2^15 cases
  function automatic logic [DW-1:0] recip_of(logic [14:0] m, logic big,
                                             logic [NumExp:0] q);
    if (big)         recip_of = DW'(64'd1 << (FracBits - 1));
    else if (m == 0) recip_of = InfStep;
    else             recip_of = DW'(q);
  endfunction

  logic [FracBits:0] fx, fy;
  logic bigx_q, bigy_q;
  assign fx = sx_q ? {1'b0, ox_q[FracBits-1:0]}
                   : (FracBits+1)'((1 << FracBits) - ox_q[FracBits-1:0]);
  assign fy = sy_q ? {1'b0, oy_q[FracBits-1:0]}
                   : (FracBits+1)'((1 << FracBits) - oy_q[FracBits-1:0]);

  // First boundary: an infinite step is a plain shift, a finite one fits NumExp+1 bits
  logic [PW-1:0] prodx, prody;
  logic [DW-1:0] mulx, muly;
  assign prodx = fx * invx_q[NumExp:0];
  assign prody = fy * invy_q[NumExp:0];
  assign mulx  = (invx_q == InfStep) ? DW'({fx, {(40 - FracBits){1'b0}}})
                                     : DW'(prodx >> FracBits);
  assign muly  = (invy_q == InfStep) ? DW'({fy, {(40 - FracBits){1'b0}}})
                                     : DW'(prody >> FracBits);

  logic stepx;
  assign stepx = nx_q < ny_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      dstart_q <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      dstart_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (action_i == gdr_pkg::ActWrite) begin
              state_q <= S_WR;
            end else begin
              ox_q <= origin_x_i; oy_q <= origin_y_i; maxd_q <= max_dist_i;
              sx_q <= dir_x_i[15]; sy_q <= dir_y_i[15];
              magx_q <= magx_in[14:0]; magy_q <= magy_in[14:0];
              bigx_q <= magx_in[15]; bigy_q <= magy_in[15];
              mx_q <= TW'({2'b00, origin_x_i[15:FracBits]});
              my_q <= TW'({2'b00, origin_y_i[15:FracBits]});
              state_q <= S_RD0;
            end
          end
        end
        S_WR: state_q <= S_IDLE;
        // Read the origin tile at the new address
        S_RD0: state_q <= S_CHK0;
        S_CHK0: begin
          // rd_q now holds origin tile
          if (!in_map || rd_q) begin
            res_q <= '0; state_q <= S_OUT;
          end else begin
            dstart_q <= 1'b1; ddiv_q <= magx_q; state_q <= S_DIVX;
          end
        end
        S_DIVX: if (ddone) begin
          invx_q <= recip_of(magx_q, bigx_q, dquot);
          dstart_q <= 1'b1; ddiv_q <= magy_q; state_q <= S_DIVY;
        end
        S_DIVY: if (ddone) begin
          invy_q <= recip_of(magy_q, bigy_q, dquot);
          state_q <= S_MULX;
        end
        S_MULX: begin nx_q <= mulx; state_q <= S_MULY; end
        S_MULY: begin ny_q <= muly; state_q <= S_STEP; end
        S_STEP: begin
          // Advance along the nearer boundary, ties in y
          dist_q <= stepx ? nx_q : ny_q;
          if ((stepx ? nx_q : ny_q) > DW'(maxd_q)) begin
            res_q <= maxd_q; state_q <= S_OUT;
          end else begin
            if (stepx) begin
              nx_q <= nx_q + invx_q; mx_q <= sx_q ? mx_q - 1'b1 : mx_q + 1'b1;
            end else begin
              ny_q <= ny_q + invy_q; my_q <= sy_q ? my_q - 1'b1 : my_q + 1'b1;
            end
            state_q <= S_LOOK;
          end
        end
        S_LOOK: state_q <= S_CHK1;
        // Stop on the tile just entered if it blocks or lies outside the map
        S_CHK1: begin
          if (!in_map || rd_q) begin
            res_q <= dist_q[15:0]; state_q <= S_OUT;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_OUT: begin done_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign hit_dist_o = res_q;

endmodule
